>>> hdl/etc_pkg.sv
// Package for the exposure timer controller: timing constants, limits,
// field widths and the item, state and result types shared by all modules.
// No dependencies.
package etc_pkg;

    localparam int TIMER_MAX_S    = 120;
    localparam int MAX_ON_S       = 300;
    localparam int TIMER_STEP     = 10;
    localparam int POWER_MIN      = 10;
    localparam int POWER_MAX      = 100;
    localparam int POWER_STEP     = 10;
    localparam int MS_PER_S       = 1000;
    localparam int PROGRESS_MS    = 200;
    localparam int PROGRESS_STEPS = 5;

    localparam int ELAPSED_LIMIT =
        (MAX_ON_S * MS_PER_S > TIMER_MAX_S * MS_PER_S + 1) ?
        MAX_ON_S * MS_PER_S : TIMER_MAX_S * MS_PER_S + 1;
    localparam int LIMIT_SECS = ELAPSED_LIMIT / MS_PER_S;
    localparam int LIMIT_SUB  = ELAPSED_LIMIT % MS_PER_S;

    localparam int TIMER_W = 7;
    localparam int POWER_W = 7;
    localparam int SHOWN_W = 9;
    localparam int PROG_W  = 3;
    localparam int SECS_W  = $clog2(LIMIT_SECS + 1);
    localparam int SUB_W   = $clog2(MS_PER_S);
    localparam int CMP_W   = (SECS_W > TIMER_W) ? SECS_W : TIMER_W;

    localparam int IN_BITS   = 6;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 2 * POWER_W + TIMER_W + 2 + SHOWN_W + PROG_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic tick;
        logic left_click;
        logic right_click;
        logic down_click;
        logic up_click;
        logic action_click;
    } item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] timer_secs;
        logic [POWER_W-1:0] power_level;
        logic               running;
        logic [SECS_W-1:0]  secs;
        logic [SUB_W-1:0]   sub_ms;
    } state_t;

    typedef struct packed {
        logic [POWER_W-1:0] pwm_compare;
        logic               lamp_on;
        logic               fan_on;
        logic [TIMER_W-1:0] timer_setting;
        logic [POWER_W-1:0] power_setting;
        logic [SHOWN_W-1:0] shown_seconds;
        logic [PROG_W-1:0]  progress;
    } result_t;

endpackage

>>> hdl/exposure_timer_controller_unit.sv
// Top level of the exposure timer controller: input register, state
// registers and result register around etc_update and etc_view.
// Depends on etc_pkg, etc_update, etc_view.
//
//  channel | dir | fields (tdata, low bit first)
//  --------+-----+-------------------------------------------------------------
//  s_      | in  | tick, left, right, down, up, action clicks
//  m_      | out | pwm_compare, lamp_on, fan_on, timer_setting, power_setting,
//          |     | shown_seconds, progress
//
// One word per cycle unless m_ stalls; a word taken on s_ passes the input
// register, then the state update and result compute in one pass, and the
// word is offered on m_ from the result register.
// Reset clears the settings to timer 0, power 100, lamp off, elapsed 0.
// A stalled result holds in the result register while one more word is taken.
module exposure_timer_controller_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tick, left_click, right_click, down_click, up_click, action_click, zeros
    input  logic [etc_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pwm_compare, lamp_on, fan_on, timer_setting, power_setting,
    // shown_seconds, progress, zeros
    output logic [etc_pkg::OUT_W-1:0] m_tdata
);

    logic             in_valid_reg;
    etc_pkg::item_t   item_reg;
    etc_pkg::item_t   item_in;
    etc_pkg::state_t  state_reg;
    etc_pkg::state_t  state_next;
    logic             out_valid_reg;
    etc_pkg::result_t out_reg;
    etc_pkg::result_t result_next;
    logic             advance;
    logic             fire;
    logic             take;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign item_in.tick         = s_tdata[0];
    assign item_in.left_click   = s_tdata[1];
    assign item_in.right_click  = s_tdata[2];
    assign item_in.down_click   = s_tdata[3];
    assign item_in.up_click     = s_tdata[4];
    assign item_in.action_click = s_tdata[5];

    etc_update u_update (
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next)
    );

    etc_view u_view (
        .state_cur (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.timer_secs  <= '0;
            state_reg.power_level <= etc_pkg::POWER_W'(etc_pkg::POWER_MAX);
            state_reg.running     <= 1'b0;
            state_reg.secs        <= '0;
            state_reg.sub_ms      <= '0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
        if (fire)
            out_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (etc_pkg::OUT_W - etc_pkg::OUT_BITS)'(0),
        out_reg.progress,
        out_reg.shown_seconds,
        out_reg.power_setting,
        out_reg.timer_setting,
        out_reg.fan_on,
        out_reg.lamp_on,
        out_reg.pwm_compare
    };

endmodule

>>> hdl/etc_update.sv
// Next-state logic of the exposure timer: elapsed count, setting clicks,
// lamp toggle and stop check for one word. Depends on etc_pkg.
module etc_update (
    input  etc_pkg::item_t  item,
    input  etc_pkg::state_t state_cur,
    output etc_pkg::state_t state_next
);

    etc_pkg::state_t n;
    logic            below_limit;

    always_comb
    begin
        n = state_cur;

        below_limit = (state_cur.secs < etc_pkg::SECS_W'(etc_pkg::LIMIT_SECS)) ||
                      ((state_cur.secs == etc_pkg::SECS_W'(etc_pkg::LIMIT_SECS)) &&
                       (state_cur.sub_ms < etc_pkg::SUB_W'(etc_pkg::LIMIT_SUB)));

        if (item.tick && below_limit)
        begin
            if (state_cur.sub_ms == etc_pkg::SUB_W'(etc_pkg::MS_PER_S - 1))
            begin
                n.sub_ms = '0;
                n.secs   = state_cur.secs + 1'b1;
            end
            else
            begin
                n.sub_ms = state_cur.sub_ms + 1'b1;
            end
        end

        if (!state_cur.running)
        begin
            if (item.left_click)
            begin
                if (n.timer_secs == '0)
                    n.timer_secs = etc_pkg::TIMER_W'(etc_pkg::TIMER_MAX_S);
                else if (n.timer_secs <= etc_pkg::TIMER_W'(etc_pkg::TIMER_STEP))
                    n.timer_secs = '0;
                else
                    n.timer_secs = n.timer_secs - etc_pkg::TIMER_W'(etc_pkg::TIMER_STEP);
            end
            if (item.right_click)
            begin
                if (n.timer_secs >= etc_pkg::TIMER_W'(etc_pkg::TIMER_MAX_S))
                    n.timer_secs = '0;
                else
                    n.timer_secs = n.timer_secs + etc_pkg::TIMER_W'(etc_pkg::TIMER_STEP);
            end
        end

        if (item.down_click)
        begin
            if (n.power_level <= etc_pkg::POWER_W'(etc_pkg::POWER_MIN))
                n.power_level = etc_pkg::POWER_W'(etc_pkg::POWER_MAX);
            else
                n.power_level = n.power_level - etc_pkg::POWER_W'(etc_pkg::POWER_STEP);
        end
        if (item.up_click)
        begin
            if (n.power_level >= etc_pkg::POWER_W'(etc_pkg::POWER_MAX))
                n.power_level = etc_pkg::POWER_W'(etc_pkg::POWER_MIN);
            else
                n.power_level = n.power_level + etc_pkg::POWER_W'(etc_pkg::POWER_STEP);
        end

        if (item.action_click)
        begin
            n.running = !state_cur.running;
            if (n.running)
            begin
                n.secs   = '0;
                n.sub_ms = '0;
            end
        end

        if (n.running)
        begin
            if (n.timer_secs != '0)
            begin
                if ((etc_pkg::CMP_W'(n.secs) > etc_pkg::CMP_W'(n.timer_secs)) ||
                    ((etc_pkg::CMP_W'(n.secs) == etc_pkg::CMP_W'(n.timer_secs)) &&
                     (n.sub_ms != '0)))
                    n.running = 1'b0;
            end
            else if (n.secs >= etc_pkg::SECS_W'(etc_pkg::MAX_ON_S))
            begin
                n.running = 1'b0;
            end
        end

        state_next = n;
    end

endmodule

>>> hdl/etc_view.sv
// Result logic of the exposure timer: PWM compare, lamp and fan enables,
// shown seconds and progress count from the updated state. Depends on etc_pkg.
module etc_view (
    input  etc_pkg::state_t  state_cur,
    output etc_pkg::result_t result
);

    logic [etc_pkg::CMP_W-1:0]  secs_x;
    logic [etc_pkg::CMP_W-1:0]  timer_x;
    logic [etc_pkg::CMP_W-1:0]  shown_x;
    logic [etc_pkg::PROG_W-1:0] prog;

    always_comb
    begin
        secs_x  = etc_pkg::CMP_W'(state_cur.secs);
        timer_x = etc_pkg::CMP_W'(state_cur.timer_secs);

        if (state_cur.timer_secs == '0)
            shown_x = secs_x;
        else if (timer_x >= secs_x)
            shown_x = timer_x - secs_x;
        else
            shown_x = '0;

        prog = '0;
        for (int k = 1; k < etc_pkg::PROGRESS_STEPS; k++)
        begin
            if (state_cur.sub_ms >= etc_pkg::SUB_W'(k * etc_pkg::PROGRESS_MS))
                prog = etc_pkg::PROG_W'(k);
        end

        result.timer_setting = state_cur.timer_secs;
        result.power_setting = state_cur.power_level;
        result.lamp_on       = state_cur.running;
        result.fan_on        = state_cur.running;
        if (state_cur.running)
        begin
            result.pwm_compare   = state_cur.power_level;
            result.shown_seconds = shown_x[etc_pkg::SHOWN_W-1:0];
            result.progress      = prog;
        end
        else
        begin
            result.pwm_compare   = '0;
            result.shown_seconds = '0;
            result.progress      = '0;
        end
    end

endmodule
